// ===== src/priority_task_scheduler_top_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the priority task scheduler
// ----------------------------------------------------------------------------
`ifndef PRIORITY_TASK_SCHEDULER_TOP_ASSERT_SVH
`define PRIORITY_TASK_SCHEDULER_TOP_ASSERT_SVH

// check a property on every rising clock edge outside reset
`define PTS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// check that a condition implies another one on the next clock edge
`define PTS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/pts_pkg.sv =====
// ----------------------------------------------------------------------------
// pts_pkg
// Shared types and constants of the priority task scheduler.
// ----------------------------------------------------------------------------
package pts_pkg;

	typedef enum logic [1:0] {
		CMD_CREATE = 2'd0,
		CMD_DELAY  = 2'd1,
		CMD_TICK   = 2'd2,
		CMD_SCHED  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DLY_RD,
		ST_DLY_WR,
		ST_SWEEP
	} state_t;

	localparam logic [7:0] IDLE_LEVEL = 8'd255;

	typedef struct packed {
		logic        active;
		logic [7:0]  prio;
		logic [31:0] wait_cnt;
	} entry_t;

	typedef struct packed {
		logic rd_en;
		logic wr_en;
	} tbl_ctl_t;

endpackage

// ===== src/priority_task_scheduler_top.sv =====
// ----------------------------------------------------------------------------
// priority_task_scheduler_top
// Fixed-priority scheduler over a task table held in one synchronous memory.
// ----------------------------------------------------------------------------
// Usage:
//   A request (cmd, task_slot, task_priority, delay_ticks) is taken on a
//   rising edge with start high and busy low.
//   Create writes the table in the accept cycle and leaves busy low.
//   Delay reads then writes the running task's entry: busy in both steps.
//   Tick and schedule sweep the table through the memory read port, one
//   entry per cycle, and stay busy until the last read has come back.
//   Schedule alone returns a result: done pulses for one cycle with
//   chosen_task and idle_fallback, in the cycle busy falls. The receiver
//   cannot stall; the result is gone after that cycle.
//   Reset clears the command state, the running task and the table valid
//   bits, so every task reads as inactive with priority and wait zero; no
//   clearing pass is needed.
// ----------------------------------------------------------------------------
module priority_task_scheduler_top #(
	parameter int NUM_TASKS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  cmd,
	input  logic [2:0]  task_slot,
	input  logic [7:0]  task_priority,
	input  logic [31:0] delay_ticks,
	output logic        done,
	output logic [2:0]  chosen_task,
	output logic        idle_fallback
);
	import pts_pkg::*;

	localparam int IDX_W = $clog2(NUM_TASKS);
	localparam int CNT_W = $clog2(NUM_TASKS + 1);

	tbl_ctl_t         tbl_ctl;
	logic [IDX_W-1:0] rd_addr;
	logic [IDX_W-1:0] wr_addr;
	entry_t           wr_data;
	entry_t           rd_data;

	pts_seq #(
		.NUM_TASKS (NUM_TASKS),
		.IDX_W     (IDX_W),
		.CNT_W     (CNT_W)
	) u_seq (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.cmd           (cmd),
		.task_slot     (task_slot),
		.task_priority (task_priority),
		.delay_ticks   (delay_ticks),
		.done          (done),
		.chosen_task   (chosen_task),
		.idle_fallback (idle_fallback),
		.tbl_ctl       (tbl_ctl),
		.rd_addr       (rd_addr),
		.wr_addr       (wr_addr),
		.wr_data       (wr_data),
		.rd_data       (rd_data)
	);

	pts_table #(
		.NUM_TASKS (NUM_TASKS),
		.IDX_W     (IDX_W)
	) u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (tbl_ctl),
		.rd_addr (rd_addr),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_data (rd_data)
	);

endmodule

// ===== src/pts_table.sv =====
// ----------------------------------------------------------------------------
// pts_table
// Task table memory, one read and one write port, registered read data.
// Per-entry valid bits make unwritten entries read as zero after reset.
// ----------------------------------------------------------------------------
module pts_table #(
	parameter int NUM_TASKS = 8,
	parameter int IDX_W     = 3
) (
	input  logic                clk,
	input  logic                arst_n,
	input  pts_pkg::tbl_ctl_t   ctl,
	input  logic [IDX_W-1:0]    rd_addr,
	input  logic [IDX_W-1:0]    wr_addr,
	input  pts_pkg::entry_t     wr_data,
	output pts_pkg::entry_t     rd_data
);
	import pts_pkg::*;

	entry_t               mem [NUM_TASKS];
	logic [NUM_TASKS-1:0] valid_q;
	entry_t               rd_q;
	logic                 rd_valid_q;

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (ctl.rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (ctl.wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (ctl.rd_en) begin
				rd_valid_q <= valid_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_valid_q ? rd_q : '0;

	`include "priority_task_scheduler_top_assert.svh"

	`PTS_ASSERT(a_no_rw_collide, !(ctl.rd_en && ctl.wr_en) || (rd_addr != wr_addr), "table read and write hit the same entry")
	`PTS_ASSERT_NEXT(a_wr_sets_valid, ctl.wr_en, valid_q[$past(wr_addr)], "written entry not marked valid")
	`PTS_ASSERT_NEXT(a_rd_hold, !ctl.rd_en, (rd_q === $past(rd_q)) && $stable(rd_valid_q), "read data changed without a read")

endmodule

// ===== src/pts_seq.sv =====
// ----------------------------------------------------------------------------
// pts_seq
// Command sequencer: accepts requests, sweeps the task table for tick and
// schedule, read-modify-writes for delay, and drives the result strobe.
// ----------------------------------------------------------------------------
module pts_seq #(
	parameter int NUM_TASKS = 8,
	parameter int IDX_W     = 3,
	parameter int CNT_W     = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [1:0]          cmd,
	input  logic [2:0]          task_slot,
	input  logic [7:0]          task_priority,
	input  logic [31:0]         delay_ticks,
	output logic                done,
	output logic [2:0]          chosen_task,
	output logic                idle_fallback,
	output pts_pkg::tbl_ctl_t   tbl_ctl,
	output logic [IDX_W-1:0]    rd_addr,
	output logic [IDX_W-1:0]    wr_addr,
	output pts_pkg::entry_t     wr_data,
	input  pts_pkg::entry_t     rd_data
);
	import pts_pkg::*;

	state_t           state_q, state_d;
	cmd_t             op_q;
	logic [31:0]      delay_q;
	logic [CNT_W-1:0] cnt_q;
	logic [IDX_W-1:0] idx_s1;
	logic             vld_s1;
	logic [IDX_W-1:0] running_q;
	logic             found_q;
	logic [7:0]       best_prio_q;
	logic [IDX_W-1:0] best_idx_q;
	logic             done_q;
	logic [2:0]       chosen_q;
	logic             idle_q;

	logic             accept;
	logic             issue;
	logic             finish;
	logic             better;
	logic             slot_ok;
	logic [IDX_W-1:0] next_run;

	assign accept  = start && (state_q == ST_IDLE);
	assign issue   = (state_q == ST_SWEEP) && (cnt_q < CNT_W'(NUM_TASKS));
	assign finish  = (state_q == ST_SWEEP) && !issue && !vld_s1;
	assign better  = rd_data.active && (rd_data.wait_cnt == 32'd0)
		&& (rd_data.prio < best_prio_q);
	assign slot_ok = 32'(task_slot) < 32'(NUM_TASKS);
	assign next_run = found_q ? best_idx_q : IDX_W'(NUM_TASKS - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		tbl_ctl.rd_en = 1'b0;
		tbl_ctl.wr_en = 1'b0;
		rd_addr       = '0;
		wr_addr       = '0;
		wr_data       = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (cmd_t'(cmd))
						CMD_CREATE: begin
							tbl_ctl.wr_en = slot_ok;
							wr_addr       = IDX_W'(task_slot);
							wr_data       = '{active: 1'b1, prio: task_priority,
								wait_cnt: 32'd0};
						end
						CMD_DELAY: state_d = ST_DLY_RD;
						CMD_TICK, CMD_SCHED: state_d = ST_SWEEP;
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_DLY_RD: begin
				tbl_ctl.rd_en = 1'b1;
				rd_addr       = running_q;
				state_d       = ST_DLY_WR;
			end
			ST_DLY_WR: begin
				tbl_ctl.wr_en = 1'b1;
				wr_addr       = running_q;
				wr_data       = '{active: rd_data.active, prio: rd_data.prio,
					wait_cnt: delay_q};
				state_d       = ST_IDLE;
			end
			ST_SWEEP: begin
				tbl_ctl.rd_en = issue;
				rd_addr       = cnt_q[IDX_W-1:0];
				if (vld_s1 && (op_q == CMD_TICK)) begin
					tbl_ctl.wr_en = rd_data.wait_cnt != 32'd0;
					wr_addr       = idx_s1;
					wr_data       = '{active: rd_data.active, prio: rd_data.prio,
						wait_cnt: rd_data.wait_cnt - 32'd1};
				end
				if (finish) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= cmd_t'(cmd);
			delay_q <= delay_ticks;
		end
		idx_s1   <= cnt_q[IDX_W-1:0];
		chosen_q <= 3'(next_run);
		idle_q   <= !found_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			vld_s1      <= 1'b0;
			running_q   <= '0;
			found_q     <= 1'b0;
			best_prio_q <= IDLE_LEVEL;
			best_idx_q  <= '0;
			done_q      <= 1'b0;
		end else begin
			done_q <= 1'b0;
			vld_s1 <= issue;
			if (accept) begin
				cnt_q       <= '0;
				found_q     <= 1'b0;
				best_prio_q <= IDLE_LEVEL;
				best_idx_q  <= '0;
			end
			if (issue) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			if (vld_s1 && (op_q == CMD_SCHED) && better) begin
				found_q     <= 1'b1;
				best_prio_q <= rd_data.prio;
				best_idx_q  <= idx_s1;
			end
			if (finish && (op_q == CMD_SCHED)) begin
				running_q <= next_run;
				done_q    <= 1'b1;
			end
		end
	end

	assign busy          = state_q != ST_IDLE;
	assign done          = done_q;
	assign chosen_task   = chosen_q;
	assign idle_fallback = idle_q;

	`include "priority_task_scheduler_top_assert.svh"

	`PTS_ASSERT(a_run_range, 32'(running_q) < 32'(NUM_TASKS), "running task out of range")
	`PTS_ASSERT_NEXT(a_done_src, finish && (op_q == CMD_SCHED), done_q && (state_q == ST_IDLE), "schedule finished without result")
	`PTS_ASSERT(a_idle_pick, !(done_q && idle_q) || (chosen_q == 3'(NUM_TASKS - 1)), "idle fallback chose a task other than the last")

endmodule

// ===== verif/tb_priority_task_scheduler_top.sv =====
// ----------------------------------------------------------------------------
// Priority task scheduler testbench
// Feeds create, delay, tick and schedule requests through the start/busy
// handshake. A local table of priorities, waits and active flags predicts
// the task picked by every schedule. The monitor matches each done pulse
// with the oldest expected pick.
// ----------------------------------------------------------------------------
module tb_priority_task_scheduler_top;
	timeunit 1ns;
	timeprecision 1ps;

	import pts_pkg::*;

	localparam int NUM_TASKS   = 8;
	localparam int RANDOM_REQS = 800;
	localparam int CYCLE_LIMIT = 400000;
	localparam int MAX_REPORTS = 10;

	typedef struct {
		cmd_t        op;
		logic [2:0]  slot;
		logic [7:0]  prio;
		logic [31:0] ticks;
	} sched_req_t;

	typedef struct {
		logic [2:0] task_id;
		logic       idle;
	} task_pick_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	cmd_t        cmd = CMD_CREATE;
	logic [2:0]  task_slot = '0;
	logic [7:0]  task_priority = '0;
	logic [31:0] delay_ticks = '0;
	logic        done;
	logic [2:0]  chosen_task;
	logic        idle_fallback;

	sched_req_t  request_q[$];
	task_pick_t  expected_picks[$];

	logic [7:0]  task_prio[NUM_TASKS];
	logic [31:0] task_wait[NUM_TASKS];
	logic        task_live[NUM_TASKS];
	int unsigned cur_task;

	int          total_reqs;
	int          n_accepted;
	int          cmd_count[4];
	int          n_picks;
	int          n_idle_picks;
	int          n_errors;
	int          n_cycles;

	priority_task_scheduler_top #(
		.NUM_TASKS(NUM_TASKS)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.cmd          (cmd),
		.task_slot    (task_slot),
		.task_priority(task_priority),
		.delay_ticks  (delay_ticks),
		.done         (done),
		.chosen_task  (chosen_task),
		.idle_fallback(idle_fallback)
	);

	always #5 clk = ~clk;

	function automatic void add_req(cmd_t op, logic [2:0] slot, logic [7:0] prio,
			logic [31:0] ticks);
		sched_req_t r;
		r.op = op;
		r.slot = slot;
		r.prio = prio;
		r.ticks = ticks;
		request_q.push_back(r);
	endfunction

	function automatic void apply_to_table(sched_req_t r);
		bit          found;
		int unsigned best_idx;
		logic [8:0]  best_prio;
		task_pick_t  pick;
		found = 1'b0;
		best_idx = 0;
		best_prio = {1'b0, IDLE_LEVEL};
		cmd_count[r.op]++;
		case (r.op)
			CMD_CREATE: begin
				if (r.slot < NUM_TASKS) begin
					task_prio[r.slot] = r.prio;
					task_wait[r.slot] = '0;
					task_live[r.slot] = 1'b1;
				end
			end
			CMD_DELAY: begin
				if (cur_task < NUM_TASKS)
					task_wait[cur_task] = r.ticks;
			end
			CMD_TICK: begin
				for (int k = 0; k < NUM_TASKS; k++)
					if (task_wait[k] != 0)
						task_wait[k] = task_wait[k] - 1;
			end
			CMD_SCHED: begin
				for (int k = 0; k < NUM_TASKS; k++) begin
					if (task_live[k] && task_wait[k] == 0 && {1'b0, task_prio[k]} < best_prio) begin
						best_prio = {1'b0, task_prio[k]};
						best_idx = k;
						found = 1'b1;
					end
				end
				cur_task = found ? best_idx : NUM_TASKS - 1;
				pick.task_id = cur_task[2:0];
				pick.idle = !found;
				expected_picks.push_back(pick);
			end
		endcase
	endfunction

	function automatic logic [7:0] rand_prio();
		return ($urandom_range(7) == 0) ? IDLE_LEVEL : 8'($urandom);
	endfunction

	function automatic logic [31:0] rand_delay();
		return ($urandom_range(15) == 0) ? 32'($urandom) : 32'($urandom_range(0, 4));
	endfunction

	initial begin
		int n_rand;
		int n_reps;
		for (int k = 0; k < NUM_TASKS; k++) begin
			task_prio[k] = '0;
			task_wait[k] = '0;
			task_live[k] = 1'b0;
		end
		cur_task = 0;

		add_req(CMD_SCHED, 3'd0, 8'd0, 32'd0);
		add_req(CMD_DELAY, 3'd0, 8'd0, 32'hFFFF_FFFF);
		add_req(CMD_TICK, 3'd7, 8'hFF, 32'd0);
		add_req(CMD_CREATE, 3'd0, IDLE_LEVEL, 32'h5555_5555);
		add_req(CMD_SCHED, 3'd0, 8'd0, 32'd0);
		add_req(CMD_CREATE, 3'd7, 8'd254, 32'd0);
		add_req(CMD_SCHED, 3'd0, 8'd0, 32'd0);
		add_req(CMD_CREATE, 3'd3, 8'd0, 32'd0);
		add_req(CMD_CREATE, 3'd5, 8'd0, 32'd0);
		add_req(CMD_SCHED, 3'd0, 8'd0, 32'd0);
		add_req(CMD_DELAY, 3'd0, 8'd0, 32'd2);
		add_req(CMD_SCHED, 3'd0, 8'd0, 32'd0);
		add_req(CMD_TICK, 3'd0, 8'd0, 32'd0);
		add_req(CMD_SCHED, 3'd0, 8'd0, 32'd0);
		add_req(CMD_TICK, 3'd0, 8'd0, 32'd0);
		add_req(CMD_SCHED, 3'd0, 8'd0, 32'd0);
		add_req(CMD_CREATE, 3'd6, 8'hAA, 32'hAAAA_AAAA);
		add_req(CMD_CREATE, 3'd1, 8'h55, 32'h5555_5555);
		add_req(CMD_SCHED, 3'd2, 8'hFF, 32'hFFFF_FFFF);
		add_req(CMD_DELAY, 3'd0, 8'd0, 32'd0);
		add_req(CMD_CREATE, 3'd3, IDLE_LEVEL, 32'd0);
		add_req(CMD_SCHED, 3'd0, 8'd0, 32'd0);
		add_req(CMD_TICK, 3'd7, 8'hFF, 32'hFFFF_FFFF);
		add_req(CMD_SCHED, 3'd7, 8'hFF, 32'hFFFF_FFFF);

		n_rand = 0;
		while (n_rand < RANDOM_REQS) begin
			if ($urandom_range(9) < 7) begin
				n_reps = $urandom_range(1, 3);
				for (int k = 0; k < n_reps; k++)
					add_req(CMD_CREATE, 3'($urandom), rand_prio(), $urandom);
				add_req(CMD_SCHED, 3'($urandom), 8'($urandom), $urandom);
				n_rand += n_reps + 1;
				n_reps = $urandom_range(1, 3);
				for (int k = 0; k < n_reps; k++) begin
					add_req(CMD_DELAY, 3'($urandom), 8'($urandom), rand_delay());
					n_rand++;
					for (int t = $urandom_range(0, 3); t > 0; t--) begin
						add_req(CMD_TICK, 3'($urandom), 8'($urandom), $urandom);
						n_rand++;
					end
					add_req(CMD_SCHED, 3'($urandom), 8'($urandom), $urandom);
					n_rand++;
				end
			end else begin
				add_req(cmd_t'($urandom_range(0, 3)), 3'($urandom), 8'($urandom), $urandom);
				n_rand++;
			end
		end
		total_reqs = request_q.size();

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		while (request_q.size() != 0 || start)
			@(negedge clk);
		while (expected_picks.size() != 0)
			@(negedge clk);
		repeat (NUM_TASKS + 6) @(negedge clk);

		n_errors += expected_picks.size();
		$display("Requests: %0d create, %0d delay, %0d tick, %0d schedule",
			cmd_count[CMD_CREATE], cmd_count[CMD_DELAY], cmd_count[CMD_TICK],
			cmd_count[CMD_SCHED]);
		$display("Picks checked: %0d, idle fallbacks among them: %0d, errors: %0d",
			n_picks, n_idle_picks, n_errors);
		if (n_errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// driver: hold a request while busy, advance from the queue otherwise
	always @(posedge clk) begin : driver
		int         idle_pct;
		sched_req_t r;
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy) begin
				r.op = cmd;
				r.slot = task_slot;
				r.prio = task_priority;
				r.ticks = delay_ticks;
				apply_to_table(r);
				n_accepted++;
			end
			if (n_accepted * 3 < total_reqs)
				idle_pct = 15;
			else if (n_accepted * 3 < total_reqs * 2)
				idle_pct = 71;
			else
				idle_pct = 0;
			if (start && busy) begin
				start <= 1'b1;
			end else if (request_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
				r = request_q.pop_front();
				start <= 1'b1;
				cmd <= r.op;
				task_slot <= r.slot;
				task_priority <= r.prio;
				delay_ticks <= r.ticks;
			end else begin
				start <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin : monitor
		task_pick_t want;
		if (arst_n && done) begin
			if (expected_picks.size() == 0) begin
				n_errors++;
				if (n_errors <= MAX_REPORTS)
					$display("Unexpected result: task %0d idle %0b", chosen_task, idle_fallback);
			end else begin
				want = expected_picks.pop_front();
				n_picks++;
				if (want.idle)
					n_idle_picks++;
				if (chosen_task !== want.task_id || idle_fallback !== want.idle) begin
					n_errors++;
					if (n_errors <= MAX_REPORTS)
						$display("Mismatch on pick %0d: expected task %0d idle %0b, got task %0d idle %0b",
							n_picks, want.task_id, want.idle, chosen_task, idle_fallback);
				end
			end
		end
	end

	always @(posedge clk) begin
		n_cycles++;
		if (n_cycles > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", n_cycles);
			$display("CHECKS FAILED");
			$finish;
		end
	end

endmodule

// ===== files.f =====
+incdir+src
src/pts_pkg.sv
src/pts_table.sv
src/pts_seq.sv
src/priority_task_scheduler_top.sv
verif/tb_priority_task_scheduler_top.sv
